@@ hw/rtl/lavm_pkg.sv @@
// Shared types, widths and helpers for the look-at view matrix block.
package lavm_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIFF_W        = DATA_W + 1;
  localparam int VEC_W         = DATA_W + 2;
  localparam int MUL_W         = 2 * VEC_W;
  localparam int SQ_W          = 2 * (DATA_W + 1);
  localparam int ROOT_W        = DATA_W + 1;
  localparam int MAG_W         = DATA_W + 1;
  localparam int Q_DEPTH       = 2;

  localparam logic [1:0] LAST_IDX = 2'd2;
  localparam logic [1:0] LAST_COL = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] tgt_x;
    logic signed [DATA_W-1:0] tgt_y;
    logic signed [DATA_W-1:0] tgt_z;
    logic signed [DATA_W-1:0] up_x;
    logic signed [DATA_W-1:0] up_y;
    logic signed [DATA_W-1:0] up_z;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] elem_row0;
    logic signed [DATA_W-1:0] elem_row1;
    logic signed [DATA_W-1:0] elem_row2;
    logic signed [DATA_W-1:0] elem_row3;
    logic [1:0]               column_index;
    logic                     last_column;
    logic                     degenerate;
  } result_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] pos;
    logic [2:0][DATA_W-1:0] up;
    logic [2:0][DIFF_W-1:0] diff;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_DIV, ST_CROSS, ST_DOT, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_Z, PH_X, PH_Y
  } phase_e;

  function automatic logic [1:0] idx_next(logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0: r = 2'd1;
      2'd1: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/look_at_view_matrix.sv @@
// Top level of the right-handed look-at view matrix block.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  input    | start, busy, item_i            | taken when start && !busy
//  result   | result_valid_o, result_o       | valid for each column, no backpressure
//
// The back end's time per transaction is set by the bit-serial square root and divider
// shared by the three normalizations. The four columns leave on consecutive cycles,
// column 3 marked last.
// A two-entry job queue lets the front take new transactions while the back works;
// busy is high only while that queue is full. Reset clears the queue and sequencer.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lavm_pkg::item_t   item_i,
  output logic              result_valid_o,
  output lavm_pkg::result_t result_o
);
  import lavm_pkg::*;

  logic job_valid, job_pop;
  job_t job;

  lavm_front u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .pop_i(job_pop), .valid_o(job_valid), .job_o(job)
  );

  lavm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .result_valid_o, .result_o
  );

endmodule

@@ hw/rtl/lavm_front.sv @@
// Front end: accepts transactions, forms pos - tgt, queues jobs for the back end.
module lavm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lavm_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output lavm_pkg::job_t job_o
);
  import lavm_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  job_t          mem_q [Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;
  job_t          job_in;

  assign busy    = (cnt_q == (PW+1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = start && !busy;
  assign pop     = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    job_in.pos  = {item_i.pos_x, item_i.pos_y, item_i.pos_z};
    job_in.up   = {item_i.up_x, item_i.up_y, item_i.up_z};
    job_in.diff = {{item_i.pos_x[DATA_W-1], item_i.pos_x} - {item_i.tgt_x[DATA_W-1], item_i.tgt_x},
                   {item_i.pos_y[DATA_W-1], item_i.pos_y} - {item_i.tgt_y[DATA_W-1], item_i.tgt_y},
                   {item_i.pos_z[DATA_W-1], item_i.pos_z} - {item_i.tgt_z[DATA_W-1], item_i.tgt_z}};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/lavm_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
module lavm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lavm_pkg::SQ_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [lavm_pkg::ROOT_W-1:0] root_o
);
  import lavm_pkg::*;

  localparam int ITER = SQ_W / 2;
  localparam int CW   = $clog2(ITER);
  localparam int RW   = ROOT_W + 2;

  logic          run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [SQ_W-1:0]   rad_q;
  logic [RW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [RW+1:0]     rem2, trial;
  logic              ge;

  assign rem2   = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial  = (RW+2)'({root_q, 2'b01});
  assign ge     = (rem2 >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(ITER - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= ge ? RW'(rem2 - trial) : RW'(rem2);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/lavm_div.sv @@
// Restoring divider: (mag << FRAC_BITS) / den, one quotient bit per cycle.
module lavm_div #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lavm_pkg::MAG_W-1:0]  mag_i,
  input  logic [lavm_pkg::ROOT_W-1:0] den_i,
  output logic                        done_o,
  output logic [FRAC_BITS:0]          quot_o
);
  import lavm_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic          run_q, done_q, first_q;
  logic [CW-1:0] cnt_q;
  logic [ROOT_W-1:0] rem_q, den_q;
  logic [QW-1:0]     quot_q;
  logic              lsb_q;
  logic [ROOT_W:0]   rem2;
  logic              ge;

  assign rem2   = {rem_q, first_q & lsb_q};
  assign ge     = (rem2 >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CW'(QW - 1);
      end else if (run_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= ROOT_W'(mag_i >> 1);
      lsb_q  <= mag_i[0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= ge ? ROOT_W'(rem2 - {1'b0, den_q}) : ROOT_W'(rem2);
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/lavm_back.sv @@
// Back end: normalizes z, x, y with shared multiplier, root and divider, emits columns.
module lavm_back #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lavm_pkg::job_t    job_i,
  output logic              job_pop_o,
  output logic              result_valid_o,
  output lavm_pkg::result_t result_o
);
  import lavm_pkg::*;

  localparam int NW = FRAC_BITS + 2;
  localparam logic signed [MUL_W:0] BIAS = (MUL_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [MUL_W:0] MAXV = (MUL_W+1)'(64'sd2147483647);
  localparam logic signed [MUL_W:0] MINV = -(MUL_W+1)'(64'sd2147483648);

  function automatic logic signed [MUL_W:0] trunc_f(logic signed [MUL_W:0] v);
    logic signed [MUL_W:0] b;
    b = v[MUL_W] ? BIAS : '0;
    return (v + b) >>> FRAC_BITS;
  endfunction

  state_e state_q, state_d;
  phase_e phase_q;
  logic [1:0] idx_q, row_q;
  logic       sub_q, wait_q, deg_q;

  logic signed [DATA_W-1:0] pos_q [3];
  logic signed [DATA_W-1:0] up_q  [3];
  logic signed [VEC_W-1:0]  vec_q [3];
  logic signed [NW-1:0]     z_q [3];
  logic signed [NW-1:0]     x_q [3];
  logic signed [NW-1:0]     y_q [3];
  logic signed [DATA_W-1:0] t_q [3];
  logic signed [MUL_W-1:0]  acc_q, p_q;
  logic [ROOT_W-1:0]        root_q;

  logic [1:0] i1, i2, ca_sel, cb_sel;
  logic signed [VEC_W-1:0] mul_a, mul_b, vsel, vabs;
  logic signed [MUL_W-1:0] prod;
  logic signed [MUL_W:0]   cross_diff, cross_tr, dot_sum, dot_tr, dot_neg;
  logic signed [DATA_W-1:0] t_new;
  logic signed [NW-1:0]    qs, norm_val;

  logic sqrt_start, sqrt_done, div_start, div_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [FRAC_BITS:0] quot;

  lavm_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(acc_q[SQ_W-1:0]),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  lavm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .mag_i(vabs[MAG_W-1:0]), .den_i(root_q),
    .done_o(div_done), .quot_o(quot)
  );

  // operand selection and unit launches
  always_comb begin
    i1     = idx_next(idx_q);
    i2     = idx_next(i1);
    ca_sel = sub_q ? i2 : i1;
    cb_sel = sub_q ? i1 : i2;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = vec_q[idx_q];
        mul_b = vec_q[idx_q];
      end
      ST_CROSS: begin
        if (phase_q == PH_X) begin
          mul_a = VEC_W'(up_q[ca_sel]);
          mul_b = VEC_W'(z_q[cb_sel]);
        end else begin
          mul_a = VEC_W'(z_q[ca_sel]);
          mul_b = VEC_W'(x_q[cb_sel]);
        end
      end
      ST_DOT: begin
        case (row_q)
          2'd0:    mul_a = VEC_W'(x_q[idx_q]);
          2'd1:    mul_a = VEC_W'(y_q[idx_q]);
          default: mul_a = VEC_W'(z_q[idx_q]);
        endcase
        mul_b = VEC_W'(pos_q[idx_q]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    sqrt_start = (state_q == ST_SQRT) && !wait_q;
    div_start  = (state_q == ST_DIV) && !wait_q;
  end

  assign prod       = mul_a * mul_b;
  assign cross_diff = $signed({p_q[MUL_W-1], p_q}) - $signed({prod[MUL_W-1], prod});
  assign cross_tr   = trunc_f(cross_diff);
  assign dot_sum    = (MUL_W+1)'(acc_q) + (MUL_W+1)'(prod);
  assign dot_tr     = trunc_f(dot_sum);
  assign dot_neg    = -dot_tr;
  assign t_new      = (dot_neg > MAXV) ? DATA_W'(MAXV) :
                      (dot_neg < MINV) ? DATA_W'(MINV) : DATA_W'(dot_neg);
  assign vsel       = vec_q[idx_q];
  assign vabs       = vsel[VEC_W-1] ? -vsel : vsel;
  assign qs         = NW'({1'b0, quot});
  assign norm_val   = vsel[VEC_W-1] ? -qs : qs;
  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_SQ;
      ST_SQ:    if (idx_q == LAST_IDX) state_d = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          if (sqrt_root != '0)      state_d = ST_DIV;
          else if (phase_q == PH_Y) state_d = ST_DOT;
          else                      state_d = ST_CROSS;
        end
      end
      ST_DIV: begin
        if (div_done && idx_q == LAST_IDX) begin
          state_d = (phase_q == PH_Y) ? ST_DOT : ST_CROSS;
        end
      end
      ST_CROSS: if (sub_q && idx_q == LAST_IDX) state_d = ST_SQ;
      ST_DOT:   if (idx_q == LAST_IDX && row_q == LAST_IDX) state_d = ST_EMIT;
      ST_EMIT:  if (idx_q == LAST_COL) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_Z;
      idx_q   <= '0;
      row_q   <= '0;
      sub_q   <= 1'b0;
      wait_q  <= 1'b0;
      deg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          phase_q <= PH_Z;
          idx_q   <= '0;
          deg_q   <= 1'b0;
        end
        ST_SQ: idx_q <= (idx_q == LAST_IDX) ? 2'd0 : idx_q + 1'b1;
        ST_SQRT: begin
          if (sqrt_start) wait_q <= 1'b1;
          if (sqrt_done) begin
            wait_q <= 1'b0;
            idx_q  <= '0;
            sub_q  <= 1'b0;
            row_q  <= '0;
            if (sqrt_root == '0) begin
              deg_q <= 1'b1;
              if (phase_q == PH_Z)      phase_q <= PH_X;
              else if (phase_q == PH_X) phase_q <= PH_Y;
            end
          end
        end
        ST_DIV: begin
          if (div_start) wait_q <= 1'b1;
          if (div_done) begin
            wait_q <= 1'b0;
            idx_q  <= (idx_q == LAST_IDX) ? 2'd0 : idx_q + 1'b1;
            sub_q  <= 1'b0;
            row_q  <= '0;
            if (idx_q == LAST_IDX) begin
              if (phase_q == PH_Z)      phase_q <= PH_X;
              else if (phase_q == PH_X) phase_q <= PH_Y;
            end
          end
        end
        ST_CROSS: begin
          sub_q <= !sub_q;
          if (sub_q) idx_q <= (idx_q == LAST_IDX) ? 2'd0 : idx_q + 1'b1;
        end
        ST_DOT: begin
          idx_q <= (idx_q == LAST_IDX) ? 2'd0 : idx_q + 1'b1;
          if (idx_q == LAST_IDX) row_q <= row_q + 1'b1;
        end
        ST_EMIT: idx_q <= idx_q + 1'b1;
        default: idx_q <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        acc_q <= '0;
        for (int i = 0; i < 3; i++) begin
          pos_q[i] <= $signed(job_i.pos[2-i]);
          up_q[i]  <= $signed(job_i.up[2-i]);
          vec_q[i] <= VEC_W'($signed(job_i.diff[2-i]));
        end
      end
      ST_SQ: acc_q <= acc_q + prod;
      ST_SQRT: begin
        if (sqrt_done) begin
          root_q <= sqrt_root;
          acc_q  <= '0;
          if (sqrt_root == '0) begin
            for (int i = 0; i < 3; i++) begin
              case (phase_q)
                PH_Z:    z_q[i] <= '0;
                PH_X:    x_q[i] <= '0;
                default: y_q[i] <= '0;
              endcase
            end
          end
        end
      end
      ST_DIV: begin
        acc_q <= '0;
        if (div_done) begin
          case (phase_q)
            PH_Z:    z_q[idx_q] <= norm_val;
            PH_X:    x_q[idx_q] <= norm_val;
            default: y_q[idx_q] <= norm_val;
          endcase
        end
      end
      ST_CROSS: begin
        acc_q <= '0;
        if (!sub_q) p_q <= prod;
        else        vec_q[idx_q] <= cross_tr[VEC_W-1:0];
      end
      ST_DOT: begin
        if (idx_q == LAST_IDX) begin
          acc_q        <= '0;
          t_q[row_q]   <= t_new;
        end else begin
          acc_q <= dot_sum[MUL_W-1:0];
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  // column output
  always_comb begin
    result_valid_o        = (state_q == ST_EMIT);
    result_o.column_index = idx_q;
    result_o.last_column  = (idx_q == LAST_COL);
    result_o.degenerate   = deg_q;
    if (idx_q == LAST_COL) begin
      result_o.elem_row0 = t_q[0];
      result_o.elem_row1 = t_q[1];
      result_o.elem_row2 = t_q[2];
      result_o.elem_row3 = DATA_W'(64'd1 << FRAC_BITS);
    end else begin
      result_o.elem_row0 = DATA_W'(x_q[idx_q]);
      result_o.elem_row1 = DATA_W'(y_q[idx_q]);
      result_o.elem_row2 = DATA_W'(z_q[idx_q]);
      result_o.elem_row3 = '0;
    end
  end

endmodule

@@ hw/rtl/lavm_checker.sv @@
// Port-level checker for the column sequence, bound to the top level.
module lavm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              result_valid_o,
  input lavm_pkg::result_t result_o
);
  import lavm_pkg::*;

  a_last_is_col3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.last_column == (result_o.column_index == LAST_COL)))
    else $error("last flag off column 3");

  a_cols_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_column |=> result_valid_o &&
      (result_o.column_index == $past(result_o.column_index) + 2'd1))
    else $error("column sequence broken");

  a_deg_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_column |=>
      (result_o.degenerate == $past(result_o.degenerate)))
    else $error("degenerate changed within transaction");

  a_row3_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_column |-> (result_o.elem_row3 == '0))
    else $error("row 3 nonzero in rotation column");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (
  .clk_i, .rst_ni, .result_valid_o, .result_o
);

@@ bench/tb.sv @@
// Self-checking testbench for the look-at view matrix: directed table, random items, predictor.
module tb;
  import lavm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef enum logic [1:0] {K_PRED, K_DEGEN, K_IDENT} row_kind_e;
  typedef struct {
    item_t     it;
    row_kind_e kind;
  } stim_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    result_valid_o;
  result_t result_o;

  result_t   column_q[$];
  int        mismatches = 0;
  int        columns_seen = 0;
  int        degen_seen = 0;
  int        items_sent = 0;
  stim_row_t dir_rows[$];

  look_at_view_matrix dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // unit vector; returns 1 when the length floors to zero
  function automatic bit unit_vec(inout longint v[3]);
    logic [127:0] sum, c;
    logic [63:0]  r, q;
    sum = 0;
    r = 0;
    for (int i = 0; i < 3; i++) sum += 128'(mag(v[i])) * 128'(mag(v[i]));
    for (int b = 36; b >= 0; b--) begin
      c = 128'(r | (64'd1 << b));
      if (c * c <= sum) r = 64'(c);
    end
    if (r == 0) begin
      v[0] = 0; v[1] = 0; v[2] = 0;
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag(v[i]) << FB) / r;
      v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = (a[1] * b[2] - a[2] * b[1]) / ONE;
    o[1] = (a[2] * b[0] - a[0] * b[2]) / ONE;
    o[2] = (a[0] * b[1] - a[1] * b[0]) / ONE;
  endfunction

  function automatic logic [31:0] translation(input longint v[3], input longint p[3]);
    longint s;
    s = -((v[0] * p[0] + v[1] * p[1] + v[2] * p[2]) / ONE);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic push_view_matrix(input item_t it);
    longint  p[3], u[3], x[3], y[3], z[3];
    bit      dg;
    result_t r;
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    u = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
    z = '{p[0] - longint'(it.tgt_x), p[1] - longint'(it.tgt_y), p[2] - longint'(it.tgt_z)};
    dg = unit_vec(z);
    cross3(u, z, x);
    dg |= unit_vec(x);
    cross3(z, x, y);
    dg |= unit_vec(y);
    if (dg) degen_seen++;
    for (int c = 0; c < 4; c++) begin
      if (c < 3) begin
        r.elem_row0 = x[c][31:0];
        r.elem_row1 = y[c][31:0];
        r.elem_row2 = z[c][31:0];
        r.elem_row3 = '0;
      end else begin
        r.elem_row0 = translation(x, p);
        r.elem_row1 = translation(y, p);
        r.elem_row2 = translation(z, p);
        r.elem_row3 = ONE[31:0];
      end
      r.column_index = 2'(c);
      r.last_column  = (c == 3);
      r.degenerate   = dg;
      column_q.push_back(r);
    end
  endtask

  // typed-in expectation for the degenerate and identity rows
  task automatic push_typed(input row_kind_e k);
    result_t r;
    for (int c = 0; c < 4; c++) begin
      r = '0;
      r.column_index = 2'(c);
      r.last_column  = (c == 3);
      if (k == K_DEGEN) begin
        r.degenerate = 1'b1;
        if (c == 3) r.elem_row3 = 32'h0001_0000;
      end else begin
        case (c)
          0: r.elem_row0 = 32'h0001_0000;
          1: r.elem_row1 = 32'h0001_0000;
          2: r.elem_row2 = 32'h0001_0000;
          default: begin
            r.elem_row2 = 32'hFFFF_0000;
            r.elem_row3 = 32'h0001_0000;
          end
        endcase
      end
      column_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && result_valid_o) begin
      columns_seen++;
      if (column_q.size() == 0) begin
        report("unexpected column", result_o[31:0], '0);
      end else begin
        w = column_q.pop_front();
        if (result_o.elem_row0 !== w.elem_row0) report("row0", result_o.elem_row0, w.elem_row0);
        if (result_o.elem_row1 !== w.elem_row1) report("row1", result_o.elem_row1, w.elem_row1);
        if (result_o.elem_row2 !== w.elem_row2) report("row2", result_o.elem_row2, w.elem_row2);
        if (result_o.elem_row3 !== w.elem_row3) report("row3", result_o.elem_row3, w.elem_row3);
        if (result_o.column_index !== w.column_index)
          report("column_index", 32'(result_o.column_index), 32'(w.column_index));
        if (result_o.last_column !== w.last_column)
          report("last_column", 32'(result_o.last_column), 32'(w.last_column));
        if (result_o.degenerate !== w.degenerate)
          report("degenerate", 32'(result_o.degenerate), 32'(w.degenerate));
      end
    end
  end

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      2: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  task automatic send(input item_t it, input row_kind_e k);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    if (k == K_PRED) push_view_matrix(it);
    else push_typed(k);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic item_t mk(input logic [31:0] px, py, pz, tx, ty, tz, ux, uy, uz);
    item_t it;
    it = '{px, py, pz, tx, ty, tz, ux, uy, uz};
    return it;
  endfunction

  initial begin
    item_t it;
    int    m, wait_cnt;
    // pos equals target: rotation and translation zero, flagged
    dir_rows.push_back('{mk(5, 6, 7, 5, 6, 7, 0, 32'h1_0000, 0), K_DEGEN});
    // camera one unit up z looking at origin
    dir_rows.push_back('{mk(0, 0, 32'h1_0000, 0, 0, 0, 0, 32'h1_0000, 0), K_IDENT});
    // up parallel to view axis
    dir_rows.push_back('{mk(0, 0, 32'h5_0000, 0, 0, 0, 0, 0, 32'h1_0000), K_PRED});
    // tiny up: cross truncates to zero
    dir_rows.push_back('{mk(3, 4, 0, 0, 0, 0, 0, 0, 1), K_PRED});
    dir_rows.push_back('{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), K_PRED});
    dir_rows.push_back('{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000), K_PRED});
    dir_rows.push_back('{mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 1, 0,
                            0, 32'h7FFF_FFFF, 32'h8000_0000), K_PRED});
    dir_rows.push_back('{mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                            32'hFFFF_FFFF, 0, 1), K_PRED});
    dir_rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 32'h1_0000), K_PRED});
    // large position drives the translation into saturation
    dir_rows.push_back('{mk(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
                            32'h7FFE_0000, 32'h7FFE_0000, 32'h7FFE_0000,
                            32'h1_0000, 0, 0), K_PRED});
    dir_rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8001_0000, 32'h8001_0000, 32'h8001_0000,
                            0, 32'h1_0000, 0), K_PRED});
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), K_DEGEN});

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].kind);

    for (int n = 0; n < 280; n++) begin
      m = $urandom_range(0, 3);
      it.pos_x = rand_coord(m); it.pos_y = rand_coord(m); it.pos_z = rand_coord(m);
      if ($urandom_range(0, 19) == 0) begin
        it.tgt_x = it.pos_x; it.tgt_y = it.pos_y; it.tgt_z = it.pos_z;
      end else begin
        m = $urandom_range(0, 3);
        it.tgt_x = rand_coord(m); it.tgt_y = rand_coord(m); it.tgt_z = rand_coord(m);
      end
      m = $urandom_range(0, 3);
      it.up_x = rand_coord(m); it.up_y = rand_coord(m); it.up_z = rand_coord(m);
      send(it, K_PRED);
      // stretch of transactions that vary only up_x
      if ($urandom_range(0, 29) == 0)
        for (int k = 0; k < 8; k++) begin
          it.up_x = rand_coord(1);
          send(it, K_PRED);
        end
    end
    start = 1'b0;

    wait_cnt = 0;
    while (column_q.size() != 0 && wait_cnt < 100_000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (400) @(posedge clk_i);

    $display("%0d transactions sent, %0d columns checked, %0d degenerate predictions",
             items_sent, columns_seen, degen_seen);
    if (mismatches == 0 && column_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d columns outstanding", mismatches, column_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lavm_pkg.sv
hw/rtl/lavm_front.sv
hw/rtl/lavm_sqrt.sv
hw/rtl/lavm_div.sv
hw/rtl/lavm_back.sv
hw/rtl/look_at_view_matrix.sv
hw/rtl/lavm_checker.sv
bench/tb.sv
